// ===== rtl/core/subtractive_random_generator_unit_assert.svh =====
// Assertion macros shared by the subtractive random generator RTL.
`ifndef SUBTRACTIVE_RANDOM_GENERATOR_UNIT_ASSERT_SVH
`define SUBTRACTIVE_RANDOM_GENERATOR_UNIT_ASSERT_SVH

// The condition cons must hold in the same cycle as ante.
`define SRG_ASSERT_IMPLY(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// The condition cons must hold in the cycle after ante.
`define SRG_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/core/srg_pkg.sv =====
// Package of constants, types and helpers for the subtractive random generator.
`default_nettype none

package srg_pkg;

   localparam int VALUE_WIDTH  = 30;
   localparam int RANGE_WIDTH  = 20;
   localparam int SEED_WIDTH   = VALUE_WIDTH + 1;

   localparam int LAG_LEN      = 55;
   localparam int SPREAD_STEP  = 21;
   localparam int FAR_OFFSET   = 30;
   localparam int TRAIL_START  = 31;
   localparam int PTR_WRAP     = 56;
   localparam int WARM_PASSES  = 4;

   localparam int PTR_WIDTH      = $clog2(PTR_WRAP);
   localparam int LAG_ADDR_WIDTH = $clog2(LAG_LEN);
   localparam int PASS_WIDTH     = $clog2(WARM_PASSES);
   localparam int BIT_WIDTH      = $clog2(RANGE_WIDTH);
   localparam int RED_CNT_WIDTH  = $clog2(SEED_WIDTH + 1);

   localparam int REQ_TDATA_WIDTH = ((SEED_WIDTH + RANGE_WIDTH + 7) / 8) * 8;
   localparam int RSP_TDATA_WIDTH = ((VALUE_WIDTH + RANGE_WIDTH + 7) / 8) * 8;

   localparam int CSR_INDEX_WIDTH = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_MODULUS    = CSR_INDEX_WIDTH'(0);
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SEED_CONST = CSR_INDEX_WIDTH'(1);

   localparam logic [VALUE_WIDTH-1:0] MODULUS_RESET    = VALUE_WIDTH'(1000000000);
   localparam logic [VALUE_WIDTH-1:0] SEED_CONST_RESET = VALUE_WIDTH'(161803398);
   localparam logic [VALUE_WIDTH-1:0] MODULUS_MIN      = VALUE_WIDTH'(2);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RED_A_GO,
      ST_RED_A_WAIT,
      ST_RED_B_GO,
      ST_RED_B_WAIT,
      ST_SUB,
      ST_SPREAD,
      ST_WARM_RD,
      ST_WARM_WR,
      ST_DRAW_RD,
      ST_DRAW_LD,
      ST_SCALE_DBL,
      ST_SCALE_ADD,
      ST_FINISH
   } state_type;

   typedef enum logic {
      ALU_SUB,
      ALU_ADD
   } alu_op_type;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] value;
      logic                   wrap;
   } alu_out_type;

   typedef struct packed {
      logic                   done;
      logic [VALUE_WIDTH-1:0] value;
   } red_out_type;

   // Advances a table pointer through 1..55, wrapping back to 1.
   function automatic logic [PTR_WIDTH-1:0] ptr_inc(input logic [PTR_WIDTH-1:0] p);
      logic [PTR_WIDTH:0] s;
      s = {1'b0, p} + (PTR_WIDTH + 1)'(1);
      if (s >= (PTR_WIDTH + 1)'(PTR_WRAP)) begin
         return PTR_WIDTH'(1);
      end
      return s[PTR_WIDTH-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/srg_lag_ram.sv =====
// Lag table memory: one write port and two registered read ports.
`default_nettype none

module srg_lag_ram
   import srg_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      wr_en,
   input  wire logic [LAG_ADDR_WIDTH-1:0] wr_addr,
   input  wire logic [VALUE_WIDTH-1:0]    wr_data,
   input  wire logic [LAG_ADDR_WIDTH-1:0] rd_addr0,
   input  wire logic [LAG_ADDR_WIDTH-1:0] rd_addr1,
   output logic      [VALUE_WIDTH-1:0]    rd_data0,
   output logic      [VALUE_WIDTH-1:0]    rd_data1
);

   logic [VALUE_WIDTH-1:0] mem [LAG_LEN];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data0 <= mem[rd_addr0];
      rd_data1 <= mem[rd_addr1];
   end

endmodule

`default_nettype wire

// ===== rtl/core/srg_alu.sv =====
// Shared modular add and subtract unit for operands below the modulus.
`default_nettype none

module srg_alu
   import srg_pkg::*;
(
   input  wire alu_op_type             op,
   input  wire logic [VALUE_WIDTH-1:0] x,
   input  wire logic [VALUE_WIDTH-1:0] y,
   input  wire logic [VALUE_WIDTH-1:0] m,
   output alu_out_type                 result
);

   logic [VALUE_WIDTH:0] diff;
   logic [VALUE_WIDTH:0] sum;
   logic [VALUE_WIDTH:0] sum_red;
   logic                 sum_ge;

   assign diff    = {1'b0, x} - {1'b0, y};
   assign sum     = {1'b0, x} + {1'b0, y};
   assign sum_ge  = sum >= {1'b0, m};
   assign sum_red = sum - {1'b0, m};

   always_comb begin
      case (op)
         ALU_SUB: begin
            // A borrow means x < y, so the modulus is added back once.
            result.wrap  = diff[VALUE_WIDTH];
            result.value = diff[VALUE_WIDTH] ? (diff[VALUE_WIDTH-1:0] + m)
                                             : diff[VALUE_WIDTH-1:0];
         end
         ALU_ADD: begin
            result.wrap  = sum_ge;
            result.value = sum_ge ? sum_red[VALUE_WIDTH-1:0] : sum[VALUE_WIDTH-1:0];
         end
         default: begin
            result.wrap  = 1'b0;
            result.value = '0;
         end
      endcase
   end

endmodule

`default_nettype wire

// ===== rtl/core/srg_reduce.sv =====
// Bit-serial remainder unit: reduces a seed-wide value modulo the modulus.
`default_nettype none

module srg_reduce
   import srg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [SEED_WIDTH-1:0]  value,
   input  wire logic [VALUE_WIDTH-1:0] m,
   output red_out_type                 result
);

   logic                     busy_ff, busy_in;
   logic                     done_ff, done_in;
   logic [RED_CNT_WIDTH-1:0] cnt_ff, cnt_in;
   logic [SEED_WIDTH-1:0]    shift_ff, shift_in;
   logic [VALUE_WIDTH-1:0]   rem_ff, rem_in;
   logic [SEED_WIDTH-1:0]    trial;
   logic [SEED_WIDTH-1:0]    trial_red;
   logic                     trial_ge;

   // One restoring step: shift in the next dividend bit, subtract if it fits.
   assign trial     = {rem_ff, shift_ff[SEED_WIDTH-1]};
   assign trial_ge  = trial >= {1'b0, m};
   assign trial_red = trial - {1'b0, m};

   always_comb begin
      busy_in  = busy_ff;
      done_in  = 1'b0;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      rem_in   = rem_ff;
      if (start) begin
         if (value < {1'b0, m}) begin
            rem_in  = value[VALUE_WIDTH-1:0];
            done_in = 1'b1;
         end else begin
            busy_in  = 1'b1;
            shift_in = value;
            rem_in   = '0;
            cnt_in   = RED_CNT_WIDTH'(SEED_WIDTH);
         end
      end else if (busy_ff) begin
         rem_in   = trial_ge ? trial_red[VALUE_WIDTH-1:0] : trial[VALUE_WIDTH-1:0];
         shift_in = {shift_ff[SEED_WIDTH-2:0], 1'b0};
         cnt_in   = cnt_ff - RED_CNT_WIDTH'(1);
         if (cnt_ff == RED_CNT_WIDTH'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
   end

   assign result.done  = done_ff;
   assign result.value = rem_ff;

endmodule

`default_nettype wire

// ===== rtl/core/subtractive_random_generator_unit.sv =====
// Top level of the subtractive random generator: sequencer and datapath.
// A draw reads two table entries, reduces each one and subtracts them; the
// scaling runs one or two shared-unit steps per bit of range_n.
// A rebuild first runs the two remainder passes, then the spread and four
// warm-up sweeps of a read and a write step per table entry.
// Throughput: one item at a time; the next item is accepted while a result waits.
// Reset is synchronous: control and CSR registers reset; the table is unseeded.
`default_nettype none

`include "subtractive_random_generator_unit_assert.svh"

module subtractive_random_generator_unit
   import srg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,

   // Request items. tdata fields from the lowest bit: seed, range_n, zero pad.
   input  wire logic                       req_tvalid,
   output logic                            req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,

   // Result items. tdata fields from the lowest bit: raw_value, scaled_value,
   // zero pad. tuser fields from the lowest bit: reinitialized.
   output logic                            rsp_tvalid,
   input  wire logic                       rsp_tready,
   output logic      [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   output logic                            rsp_tuser,

   // Register writes: modulus at index 0, seed constant at index 1.
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [VALUE_WIDTH-1:0]     csr_wdata
);

   state_type state_ff, state_in;

   logic [VALUE_WIDTH-1:0]    modulus_ff;
   logic [VALUE_WIDTH-1:0]    seed_const_ff;
   logic [VALUE_WIDTH-1:0]    m_eff;

   logic                      seeded_ff, seeded_in;
   logic                      reinit_ff, reinit_in;
   logic                      draw_ff, draw_in;
   logic [PTR_WIDTH-1:0]      lead_ff, lead_in;
   logic [PTR_WIDTH-1:0]      trail_ff, trail_in;
   logic [RANGE_WIDTH-1:0]    range_ff, range_in;
   logic [SEED_WIDTH-1:0]     opa_ff, opa_in;
   logic [SEED_WIDTH-1:0]     opb_ff, opb_in;
   logic [VALUE_WIDTH-1:0]    x_ff, x_in;
   logic [VALUE_WIDTH-1:0]    y_ff, y_in;
   logic [VALUE_WIDTH-1:0]    raw_ff, raw_in;
   logic [RANGE_WIDTH-1:0]    quo_ff, quo_in;
   logic [BIT_WIDTH-1:0]      bit_ff, bit_in;
   logic [LAG_ADDR_WIDTH-1:0] spread_ff, spread_in;
   logic [LAG_ADDR_WIDTH-1:0] cnt_ff, cnt_in;
   logic [LAG_ADDR_WIDTH-1:0] addr_ff, addr_in;
   logic [LAG_ADDR_WIDTH-1:0] far_ff, far_in;
   logic [PASS_WIDTH-1:0]     pass_ff, pass_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_WIDTH-1:0] rsp_data_ff, rsp_data_in;
   logic                      rsp_user_ff, rsp_user_in;

   logic                      req_fire;
   logic                      out_free;
   logic                      need_rebuild;
   logic [SEED_WIDTH-1:0]     req_seed;
   logic [SEED_WIDTH-1:0]     req_mag;
   logic [LAG_ADDR_WIDTH:0]   spread_sum;
   logic                      warm_last;

   // Shared unit, remainder unit and table memory connections.
   alu_op_type                alu_op;
   logic [VALUE_WIDTH-1:0]    alu_x;
   logic [VALUE_WIDTH-1:0]    alu_y;
   alu_out_type               alu_out;
   logic                      red_start;
   logic [SEED_WIDTH-1:0]     red_value;
   red_out_type               red_out;
   logic                      wr_en;
   logic [LAG_ADDR_WIDTH-1:0] wr_addr;
   logic [VALUE_WIDTH-1:0]    wr_data;
   logic [LAG_ADDR_WIDTH-1:0] rd_addr0;
   logic [LAG_ADDR_WIDTH-1:0] rd_addr1;
   logic [VALUE_WIDTH-1:0]    rd_data0;
   logic [VALUE_WIDTH-1:0]    rd_data1;

   srg_alu u_alu (
      .op     (alu_op),
      .x      (alu_x),
      .y      (alu_y),
      .m      (m_eff),
      .result (alu_out)
   );

   srg_reduce u_reduce (
      .clock  (clock),
      .reset  (reset),
      .start  (red_start),
      .value  (red_value),
      .m      (m_eff),
      .result (red_out)
   );

   srg_lag_ram u_ram (
      .clock    (clock),
      .wr_en    (wr_en),
      .wr_addr  (wr_addr),
      .wr_data  (wr_data),
      .rd_addr0 (rd_addr0),
      .rd_addr1 (rd_addr1),
      .rd_data0 (rd_data0),
      .rd_data1 (rd_data1)
   );

   // A modulus below two behaves as two.
   assign m_eff = (modulus_ff < MODULUS_MIN) ? MODULUS_MIN : modulus_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   assign req_seed     = req_tdata[SEED_WIDTH-1:0];
   assign req_mag      = req_seed[SEED_WIDTH-1] ? (~req_seed + SEED_WIDTH'(1)) : req_seed;
   assign need_rebuild = req_seed[SEED_WIDTH-1] || !seeded_ff;

   // Entry numbers 21*i mod 55 are generated by repeated addition.
   assign spread_sum = {1'b0, spread_ff} + (LAG_ADDR_WIDTH + 1)'(SPREAD_STEP);
   assign warm_last  = (addr_ff == LAG_ADDR_WIDTH'(LAG_LEN - 1))
                    && (pass_ff == PASS_WIDTH'(WARM_PASSES - 1));

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = need_rebuild ? ST_RED_A_GO : ST_DRAW_RD;
            end
         end
         ST_RED_A_GO:   state_in = ST_RED_A_WAIT;
         ST_RED_A_WAIT: if (red_out.done) state_in = ST_RED_B_GO;
         ST_RED_B_GO:   state_in = ST_RED_B_WAIT;
         ST_RED_B_WAIT: if (red_out.done) state_in = ST_SUB;
         ST_SUB:        state_in = draw_ff ? ST_SCALE_DBL : ST_SPREAD;
         ST_SPREAD: begin
            if (cnt_ff == LAG_ADDR_WIDTH'(LAG_LEN - 1)) begin
               state_in = ST_WARM_RD;
            end
         end
         ST_WARM_RD:    state_in = ST_WARM_WR;
         ST_WARM_WR:    state_in = warm_last ? ST_DRAW_RD : ST_WARM_RD;
         ST_DRAW_RD:    state_in = ST_DRAW_LD;
         ST_DRAW_LD:    state_in = ST_RED_A_GO;
         ST_SCALE_DBL: begin
            if (range_ff[bit_ff]) begin
               state_in = ST_SCALE_ADD;
            end else if (bit_ff == '0) begin
               state_in = ST_FINISH;
            end
         end
         ST_SCALE_ADD:  state_in = (bit_ff == '0) ? ST_FINISH : ST_SCALE_DBL;
         ST_FINISH:     if (out_free) state_in = ST_IDLE;
         default:       state_in = ST_IDLE;
      endcase
   end

   // Datapath controls and register updates for each state.
   always_comb begin
      seeded_in    = seeded_ff;
      reinit_in    = reinit_ff;
      draw_in      = draw_ff;
      lead_in      = lead_ff;
      trail_in     = trail_ff;
      range_in     = range_ff;
      opa_in       = opa_ff;
      opb_in       = opb_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      raw_in       = raw_ff;
      quo_in       = quo_ff;
      bit_in       = bit_ff;
      spread_in    = spread_ff;
      cnt_in       = cnt_ff;
      addr_in      = addr_ff;
      far_in       = far_ff;
      pass_in      = pass_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_user_in  = rsp_user_ff;
      rsp_valid_in = rsp_valid_ff;

      alu_op    = ALU_SUB;
      alu_x     = x_ff;
      alu_y     = y_ff;
      red_start = 1'b0;
      red_value = opa_ff;
      wr_en     = 1'b0;
      wr_addr   = LAG_ADDR_WIDTH'(lead_ff - PTR_WIDTH'(1));
      wr_data   = alu_out.value;
      rd_addr0  = addr_ff;
      rd_addr1  = far_ff;

      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               range_in  = req_tdata[SEED_WIDTH +: RANGE_WIDTH];
               reinit_in = need_rebuild;
               draw_in   = 1'b0;
               opa_in    = {1'b0, seed_const_ff};
               opb_in    = req_mag;
            end
         end
         ST_RED_A_GO: begin
            red_start = 1'b1;
            red_value = opa_ff;
         end
         ST_RED_A_WAIT: begin
            if (red_out.done) begin
               x_in = red_out.value;
            end
         end
         ST_RED_B_GO: begin
            red_start = 1'b1;
            red_value = opb_ff;
         end
         ST_RED_B_WAIT: begin
            if (red_out.done) begin
               y_in = red_out.value;
            end
         end
         ST_SUB: begin
            wr_en = 1'b1;
            if (!draw_ff) begin
               // Seed value goes to entry 55; the running value starts at one.
               wr_addr   = LAG_ADDR_WIDTH'(LAG_LEN - 1);
               x_in      = alu_out.value;
               y_in      = VALUE_WIDTH'(1);
               spread_in = LAG_ADDR_WIDTH'(SPREAD_STEP);
               cnt_in    = LAG_ADDR_WIDTH'(1);
            end else begin
               raw_in = alu_out.value;
               x_in   = '0;
               quo_in = '0;
               bit_in = BIT_WIDTH'(RANGE_WIDTH - 1);
            end
         end
         ST_SPREAD: begin
            // Store the running value, then step the two-term recurrence.
            wr_en   = 1'b1;
            wr_addr = spread_ff - LAG_ADDR_WIDTH'(1);
            wr_data = y_ff;
            y_in    = alu_out.value;
            x_in    = y_ff;
            cnt_in  = cnt_ff + LAG_ADDR_WIDTH'(1);
            if (spread_sum >= (LAG_ADDR_WIDTH + 1)'(LAG_LEN)) begin
               spread_in = LAG_ADDR_WIDTH'(spread_sum - (LAG_ADDR_WIDTH + 1)'(LAG_LEN));
            end else begin
               spread_in = spread_sum[LAG_ADDR_WIDTH-1:0];
            end
            if (cnt_ff == LAG_ADDR_WIDTH'(LAG_LEN - 1)) begin
               addr_in = '0;
               far_in  = LAG_ADDR_WIDTH'(FAR_OFFSET + 1);
               pass_in = '0;
            end
         end
         ST_WARM_RD: begin
            rd_addr0 = addr_ff;
            rd_addr1 = far_ff;
         end
         ST_WARM_WR: begin
            alu_x   = rd_data0;
            alu_y   = rd_data1;
            wr_en   = 1'b1;
            wr_addr = addr_ff;
            if (addr_ff == LAG_ADDR_WIDTH'(LAG_LEN - 1)) begin
               addr_in = '0;
               pass_in = pass_ff + PASS_WIDTH'(1);
            end else begin
               addr_in = addr_ff + LAG_ADDR_WIDTH'(1);
            end
            if (far_ff == LAG_ADDR_WIDTH'(LAG_LEN - 1)) begin
               far_in = '0;
            end else begin
               far_in = far_ff + LAG_ADDR_WIDTH'(1);
            end
            if (warm_last) begin
               lead_in   = '0;
               trail_in  = PTR_WIDTH'(TRAIL_START);
               seeded_in = 1'b1;
            end
         end
         ST_DRAW_RD: begin
            lead_in  = ptr_inc(lead_ff);
            trail_in = ptr_inc(trail_ff);
            rd_addr0 = LAG_ADDR_WIDTH'(lead_in - PTR_WIDTH'(1));
            rd_addr1 = LAG_ADDR_WIDTH'(trail_in - PTR_WIDTH'(1));
         end
         ST_DRAW_LD: begin
            opa_in  = {1'b0, rd_data0};
            opb_in  = {1'b0, rd_data1};
            draw_in = 1'b1;
         end
         ST_SCALE_DBL: begin
            // Remainder doubles modulo m; a wrap is a quotient bit.
            alu_op = ALU_ADD;
            alu_x  = x_ff;
            alu_y  = x_ff;
            x_in   = alu_out.value;
            quo_in = {quo_ff[RANGE_WIDTH-2:0], 1'b0} + RANGE_WIDTH'(alu_out.wrap);
            if (!range_ff[bit_ff] && (bit_ff != '0)) begin
               bit_in = bit_ff - BIT_WIDTH'(1);
            end
         end
         ST_SCALE_ADD: begin
            alu_op = ALU_ADD;
            alu_x  = x_ff;
            alu_y  = raw_ff;
            x_in   = alu_out.value;
            quo_in = quo_ff + RANGE_WIDTH'(alu_out.wrap);
            if (bit_ff != '0) begin
               bit_in = bit_ff - BIT_WIDTH'(1);
            end
         end
         ST_FINISH: begin
            if (out_free) begin
               rsp_data_in  = RSP_TDATA_WIDTH'({quo_ff, raw_ff});
               rsp_user_in  = reinit_ff;
               rsp_valid_in = 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   // Configuration registers; unknown indexes are ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         modulus_ff    <= MODULUS_RESET;
         seed_const_ff <= SEED_CONST_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MODULUS:    modulus_ff    <= csr_wdata;
            CSR_SEED_CONST: seed_const_ff <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         seeded_ff    <= 1'b0;
         draw_ff      <= 1'b0;
         lead_ff      <= '0;
         trail_ff     <= PTR_WIDTH'(TRAIL_START);
         cnt_ff       <= '0;
         addr_ff      <= '0;
         far_ff       <= '0;
         pass_ff      <= '0;
         bit_ff       <= '0;
         spread_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         seeded_ff    <= seeded_in;
         draw_ff      <= draw_in;
         lead_ff      <= lead_in;
         trail_ff     <= trail_in;
         cnt_ff       <= cnt_in;
         addr_ff      <= addr_in;
         far_ff       <= far_in;
         pass_ff      <= pass_in;
         bit_ff       <= bit_in;
         spread_ff    <= spread_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      reinit_ff   <= reinit_in;
      range_ff    <= range_in;
      opa_ff      <= opa_in;
      opb_ff      <= opb_in;
      x_ff        <= x_in;
      y_ff        <= y_in;
      raw_ff      <= raw_in;
      quo_ff      <= quo_in;
      rsp_data_ff <= rsp_data_in;
      rsp_user_ff <= rsp_user_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_user_ff;

   `SRG_ASSERT_IMPLY(a_lead_range, state_ff == ST_DRAW_LD,
      lead_ff != '0 && lead_ff < PTR_WRAP, "lead pointer outside 1..55 at draw")
   `SRG_ASSERT_IMPLY(a_spread_slot, state_ff == ST_SPREAD,
      spread_ff != '0 && spread_ff < LAG_LEN, "spread entry outside 1..54")
   `SRG_ASSERT_IMPLY(a_scale_bit, state_ff == ST_SCALE_ADD,
      range_ff[bit_ff], "scaling add step taken for a clear range bit")
   `SRG_ASSERT_NEXT(a_seeded_sticky, seeded_ff, seeded_ff, "seeded flag dropped")

endmodule

`default_nettype wire

// ===== tb/subtractive_random_generator_checker.sv =====
`timescale 1ns / 100ps
// Checker that predicts every draw of the subtractive generator and compares the results.
module subtractive_random_generator_checker
   import srg_pkg::*;
(
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       req_tvalid,
   input  wire logic                       req_tready,
   input  wire logic [REQ_TDATA_WIDTH-1:0] req_tdata,
   input  wire logic                       rsp_tvalid,
   input  wire logic                       rsp_tready,
   input  wire logic [RSP_TDATA_WIDTH-1:0] rsp_tdata,
   input  wire logic                       rsp_tuser,
   input  wire logic                       csr_we,
   input  wire logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [VALUE_WIDTH-1:0]     csr_wdata,
   output int                              mismatch_count,
   output int                              draws_outstanding
);

   localparam int REPORT_LIMIT = 20;

   typedef struct packed {
      logic [VALUE_WIDTH-1:0] raw_value;
      logic [RANGE_WIDTH-1:0] scaled_value;
      logic                   reinitialized;
   } draw_t;

   longint unsigned lag_words[LAG_LEN];
   longint unsigned modulus_reg;
   longint unsigned seed_const_reg;
   int              lead_ptr;
   int              trail_ptr;
   bit              seeded;
   draw_t           expected_draws[$];

   // Difference of the two residues, kept in 0 .. m-1 whatever the operands are.
   function automatic longint unsigned residue_diff(input longint unsigned a,
                                                    input longint unsigned b,
                                                    input longint unsigned m);
      longint unsigned x;
      longint unsigned y;
      x = a % m;
      y = b % m;
      return (x >= y) ? x - y : x + m - y;
   endfunction

   function automatic void reseed_table(input logic [SEED_WIDTH-1:0] seed_bits,
                                        input longint unsigned m);
      logic [SEED_WIDTH-1:0] negated;
      longint unsigned       mag;
      longint unsigned       mj;
      longint unsigned       mk;
      longint unsigned       held;
      int                    slot;
      negated = '0 - seed_bits;
      mag = seed_bits[SEED_WIDTH-1] ? negated : seed_bits;
      mj = residue_diff(seed_const_reg, mag, m);
      lag_words[LAG_LEN-1] = mj;
      mk = 1;
      // Spread the running values over the table in steps of 21.
      for (int i = 1; i < LAG_LEN; i++) begin
         slot = (SPREAD_STEP * i) % LAG_LEN;
         held = mk;
         lag_words[slot-1] = held;
         mk = residue_diff(mj, mk, m);
         mj = held;
      end
      for (int pass = 0; pass < WARM_PASSES; pass++) begin
         for (int i = 1; i <= LAG_LEN; i++) begin
            lag_words[i-1] = residue_diff(lag_words[i-1], lag_words[(i + FAR_OFFSET) % LAG_LEN], m);
         end
      end
      lead_ptr = 0;
      trail_ptr = TRAIL_START;
      seeded = 1'b1;
   endfunction

   function automatic draw_t predict_draw(input logic [SEED_WIDTH-1:0] seed_bits,
                                          input logic [RANGE_WIDTH-1:0] range_n);
      longint unsigned m;
      longint unsigned raw;
      longint unsigned product;
      draw_t           d;
      m = (modulus_reg < MODULUS_MIN) ? MODULUS_MIN : modulus_reg;
      d.reinitialized = 1'b0;
      if (seed_bits[SEED_WIDTH-1] || !seeded) begin
         reseed_table(seed_bits, m);
         d.reinitialized = 1'b1;
      end
      lead_ptr = (lead_ptr + 1 >= PTR_WRAP) ? 1 : lead_ptr + 1;
      trail_ptr = (trail_ptr + 1 >= PTR_WRAP) ? 1 : trail_ptr + 1;
      raw = residue_diff(lag_words[lead_ptr-1], lag_words[trail_ptr-1], m);
      lag_words[lead_ptr-1] = raw;
      product = range_n;
      product = (product * raw) / m;
      d.raw_value = raw[VALUE_WIDTH-1:0];
      d.scaled_value = product[RANGE_WIDTH-1:0];
      return d;
   endfunction

   function automatic void note_mismatch(input string field, input longint unsigned want,
                                         input longint unsigned got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT) begin
         $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
      end
   endfunction

   always @(posedge clock) begin : watch
      draw_t want;
      if (reset) begin
         modulus_reg = MODULUS_RESET;
         seed_const_reg = SEED_CONST_RESET;
         lead_ptr = 0;
         trail_ptr = TRAIL_START;
         seeded = 1'b0;
         expected_draws.delete();
         mismatch_count = 0;
         draws_outstanding = 0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_draws.size() == 0) begin
               mismatch_count++;
               $display("%0t ns: result item with nothing expected, expected none, actual raw %0d",
                        $time, rsp_tdata[VALUE_WIDTH-1:0]);
            end else begin
               want = expected_draws.pop_front();
               if (rsp_tdata[VALUE_WIDTH-1:0] !== want.raw_value)
                  note_mismatch("raw_value", want.raw_value, rsp_tdata[VALUE_WIDTH-1:0]);
               if (rsp_tdata[VALUE_WIDTH +: RANGE_WIDTH] !== want.scaled_value)
                  note_mismatch("scaled_value", want.scaled_value,
                                rsp_tdata[VALUE_WIDTH +: RANGE_WIDTH]);
               if (rsp_tuser !== want.reinitialized)
                  note_mismatch("reinitialized", want.reinitialized, rsp_tuser);
            end
         end
         if (req_tvalid && req_tready) begin
            expected_draws.push_back(predict_draw(req_tdata[SEED_WIDTH-1:0],
                                                  req_tdata[SEED_WIDTH +: RANGE_WIDTH]));
         end
         if (csr_we) begin
            case (csr_index)
               CSR_MODULUS: begin
                  modulus_reg = csr_wdata;
               end
               CSR_SEED_CONST: begin
                  seed_const_reg = csr_wdata;
               end
               default: begin
               end
            endcase
         end
         draws_outstanding = expected_draws.size();
      end
   end

endmodule

// ===== tb/tb_subtractive_random_generator_unit.sv =====
`timescale 1ns / 100ps
// Top of the subtractive generator testbench: clock, reset, stimulus and verdict.
module tb_subtractive_random_generator_unit
   import srg_pkg::*;
;

   // Register indexes that the block does not decode; writes to them must be ignored.
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_LOW  = 2;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_SPARE_HIGH = 3;

   localparam logic [VALUE_WIDTH-1:0] VALUE_MAX = {VALUE_WIDTH{1'b1}};
   localparam logic [RANGE_WIDTH-1:0] RANGE_MAX = {RANGE_WIDTH{1'b1}};

   // A reseed and a draw both end well within WATCHDOG_LIMIT, so a quiet spell of
   // that length can only mean that the block has hung.
   localparam int WATCHDOG_LIMIT  = 20000;
   localparam int DRAIN_CYCLES    = 600;
   localparam int RANDOM_PHASES   = 12;
   localparam int ITEMS_PER_PHASE = 152;

   typedef enum int {
      READY_ALWAYS,
      READY_COIN,
      READY_EVERY_FOURTH,
      READY_RARE
   } ready_mode_t;

   logic                       clock = 1'b0;
   logic                       reset;
   logic                       req_tvalid;
   logic                       req_tready;
   logic [REQ_TDATA_WIDTH-1:0] req_tdata;   // seed, range_n, zero pad
   logic                       rsp_tvalid;
   logic                       rsp_tready;
   logic [RSP_TDATA_WIDTH-1:0] rsp_tdata;   // raw_value, scaled_value, zero pad
   logic                       rsp_tuser;   // reinitialized
   logic                       csr_we;
   logic [CSR_INDEX_WIDTH-1:0] csr_index;
   logic [VALUE_WIDTH-1:0]     csr_wdata;

   int mismatch_count;
   int draws_outstanding;

   // Bookkeeping for the sender and the closing summary.
   int items_sent;
   int negative_seeds;
   int reg_writes;
   int burst_left;
   int gap_max;
   int idle_cycles;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   subtractive_random_generator_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // The checker sees the same pins as the block and keeps its own model of it.
   subtractive_random_generator_checker draw_checker (
      .clock             (clock),
      .reset             (reset),
      .req_tvalid        (req_tvalid),
      .req_tready        (req_tready),
      .req_tdata         (req_tdata),
      .rsp_tvalid        (rsp_tvalid),
      .rsp_tready        (rsp_tready),
      .rsp_tdata         (rsp_tdata),
      .rsp_tuser         (rsp_tuser),
      .csr_we            (csr_we),
      .csr_index         (csr_index),
      .csr_wdata         (csr_wdata),
      .mismatch_count    (mismatch_count),
      .draws_outstanding (draws_outstanding)
   );

   // Two's complement encoding of minus mag in the seed field.
   function automatic logic [SEED_WIDTH-1:0] negative_seed(input logic [VALUE_WIDTH-1:0] mag);
      return '0 - {1'b0, mag};
   endfunction

   // Offers one item, holds it until the block takes it and then, at the end of
   // a burst, drops valid for a random gap. The caller is always at a falling
   // edge, so valid is never lowered and raised in the same time step.
   task automatic issue_item(input logic [SEED_WIDTH-1:0] seed,
                             input logic [RANGE_WIDTH-1:0] range_n);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
      end
      req_tdata = REQ_TDATA_WIDTH'({range_n, seed});
      req_tvalid = 1'b1;
      do begin
         @(posedge clock);
      end while (!req_tready);
      @(negedge clock);
      items_sent++;
      if (seed[SEED_WIDTH-1]) begin
         negative_seeds++;
      end
      burst_left--;
      if (burst_left == 0) begin
         gap = $urandom_range(0, gap_max);
         if (gap > 0) begin
            req_tvalid = 1'b0;
            repeat (gap) @(negedge clock);
         end
      end
   endtask

   // Stops sending and waits until every predicted result has come back.
   // Registers are only ever written after this, when the block is idle.
   task automatic settle();
      req_tvalid = 1'b0;
      burst_left = 0;
      while (draws_outstanding != 0) begin
         @(negedge clock);
      end
   endtask

   task automatic write_reg(input logic [CSR_INDEX_WIDTH-1:0] index,
                            input logic [VALUE_WIDTH-1:0] value);
      csr_we = 1'b1;
      csr_index = index;
      csr_wdata = value;
      @(negedge clock);
      csr_we = 1'b0;
      reg_writes++;
   endtask

   // The receiver switches between stall patterns of random length, one of
   // which never stalls at all.
   initial begin : receiver
      ready_mode_t mode;
      int          span;
      rsp_tready = 1'b0;
      forever begin
         mode = ready_mode_t'($urandom_range(0, 3));
         span = $urandom_range(16, 256);
         for (int tick = 0; tick < span; tick++) begin
            @(negedge clock);
            case (mode)
               READY_ALWAYS: begin
                  rsp_tready = 1'b1;
               end
               READY_COIN: begin
                  rsp_tready = $urandom_range(0, 1);
               end
               READY_EVERY_FOURTH: begin
                  rsp_tready = (tick % 4 == 3);
               end
               default: begin
                  rsp_tready = ($urandom_range(0, 15) == 0);
               end
            endcase
         end
      end
   end

   // The watchdog ends the run if no item moves on either channel for too long.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("%0t ns: no item moved for %0d cycles", $time, idle_cycles);
         $display("Verification failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin : stimulus
      logic [SEED_WIDTH-1:0]  seed;
      logic [RANGE_WIDTH-1:0] range_n;
      logic [VALUE_WIDTH-1:0] value;
      int                     pick;

      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_we = 1'b0;
      csr_index = CSR_MODULUS;
      csr_wdata = '0;
      items_sent = 0;
      negative_seeds = 0;
      reg_writes = 0;
      burst_left = 0;
      gap_max = 4;
      idle_cycles = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed part. The first item after reset must rebuild the table even
      // though its seed is positive; negative seeds at both ends of the range
      // force further rebuilds.
      issue_item(SEED_WIDTH'(12345), RANGE_MAX);
      issue_item(SEED_WIDTH'(0), RANGE_WIDTH'(0));
      issue_item({1'b0, VALUE_MAX}, RANGE_WIDTH'(1));
      issue_item(negative_seed(VALUE_WIDTH'(1)), RANGE_MAX);
      issue_item(negative_seed(VALUE_MAX), RANGE_WIDTH'(1) << (RANGE_WIDTH - 1));
      issue_item(SEED_WIDTH'(1), RANGE_WIDTH'(3));
      issue_item(SEED_WIDTH'(100), RANGE_MAX);
      issue_item(SEED_WIDTH'(7), RANGE_WIDTH'(0));
      issue_item(SEED_WIDTH'(2), RANGE_MAX);

      // Raise the modulus to its maximum without reseeding: the table still
      // holds residues of the old modulus.
      settle();
      write_reg(CSR_MODULUS, VALUE_MAX);
      issue_item(SEED_WIDTH'(5), RANGE_MAX);
      issue_item(SEED_WIDTH'(6), RANGE_WIDTH'(1));
      issue_item(SEED_WIDTH'(8), RANGE_MAX);

      // A zero seed constant makes the seed difference negative, so the subtraction
      // borrows and the modulus is added back.
      settle();
      write_reg(CSR_SEED_CONST, VALUE_WIDTH'(0));
      issue_item(negative_seed(VALUE_WIDTH'(5)), RANGE_MAX);
      issue_item(SEED_WIDTH'(9), RANGE_WIDTH'(77));

      // A modulus below two behaves as two, both on a rebuild and after one.
      settle();
      write_reg(CSR_MODULUS, VALUE_WIDTH'(1));
      issue_item(negative_seed(VALUE_WIDTH'(7)), RANGE_MAX);
      issue_item(SEED_WIDTH'(3), RANGE_MAX);
      settle();
      write_reg(CSR_MODULUS, VALUE_WIDTH'(0));
      issue_item(SEED_WIDTH'(4), RANGE_MAX);
      issue_item(SEED_WIDTH'(10), RANGE_WIDTH'(1));

      // Writes to undecoded indexes must leave both registers alone.
      settle();
      write_reg(CSR_SPARE_LOW, VALUE_MAX);
      write_reg(CSR_SPARE_HIGH, VALUE_WIDTH'(12345));
      issue_item(SEED_WIDTH'(11), RANGE_MAX);

      // Smallest legal modulus with the largest seed constant and seed magnitude.
      settle();
      write_reg(CSR_SEED_CONST, VALUE_MAX);
      write_reg(CSR_MODULUS, MODULUS_MIN);
      issue_item(negative_seed(VALUE_MAX), RANGE_MAX);
      issue_item(SEED_WIDTH'(12), RANGE_MAX);
      issue_item(SEED_WIDTH'(13), RANGE_WIDTH'(1));

      // Random part. Each phase first lets the block drain, then may pick a new
      // register setting, and picks a new burst shape. Most seeds are positive so
      // that draws dominate; a few negative seeds reseed the table.
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         settle();
         if ($urandom_range(0, 4) != 0) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: value = VALUE_MAX;
               1: value = $urandom_range(0, 1);
               2: value = $urandom_range(2, 1000);
               3: value = MODULUS_RESET;
               default: value = $urandom_range(2, VALUE_MAX);
            endcase
            write_reg(CSR_MODULUS, value);
         end
         if ($urandom_range(0, 2) != 0) begin
            pick = $urandom_range(0, 5);
            case (pick)
               0: value = '0;
               1: value = VALUE_MAX;
               default: value = $urandom_range(0, VALUE_MAX);
            endcase
            write_reg(CSR_SEED_CONST, value);
         end
         if ($urandom_range(0, 5) == 0) begin
            write_reg($urandom_range(0, 1) ? CSR_SPARE_LOW : CSR_SPARE_HIGH,
                      $urandom_range(0, VALUE_MAX));
         end
         // Some phases send back to back with no gaps at all.
         gap_max = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);

         for (int count = 0; count < ITEMS_PER_PHASE; count++) begin
            pick = $urandom_range(0, 99);
            if ((count == 0 && $urandom_range(0, 1) == 1) || pick < 5) begin
               seed = negative_seed($urandom_range(1, VALUE_MAX));
            end else if (pick < 7) begin
               seed = $urandom_range(0, 1) ? {1'b0, VALUE_MAX} : SEED_WIDTH'(0);
            end else begin
               seed = {1'b0, VALUE_WIDTH'($urandom_range(0, VALUE_MAX))};
            end
            pick = $urandom_range(0, 9);
            case (pick)
               0: range_n = '0;
               1: range_n = RANGE_MAX;
               2: range_n = $urandom_range(1, 15);
               3: range_n = RANGE_WIDTH'(1) << $urandom_range(0, RANGE_WIDTH - 1);
               default: range_n = $urandom_range(0, RANGE_MAX);
            endcase
            issue_item(seed, range_n);
            // Now and then the sender holds off until the block is empty.
            if ($urandom_range(0, 199) == 0) begin
               settle();
            end
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(negedge clock);

      $display("Run summary: %0d request items, %0d of them with negative seeds,",
               items_sent, negative_seeds);
      $display("Run summary: %0d register writes over %0d random settings, %0d mismatches.",
               reg_writes, RANDOM_PHASES, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
